[hw/rtl/ucer_pkg.sv]
// Package for the USB control endpoint request block: transfer structs,
// event, stage, action, report and request codes, and size limits. No dependencies.
package ucer_pkg;

	// Event codes on the cmd field
	localparam logic [1:0] CMD_SETUP   = 2'd0;
	localparam logic [1:0] CMD_RX_DONE = 2'd1;
	localparam logic [1:0] CMD_TX_DONE = 2'd2;
	localparam logic [1:0] CMD_BUS_RST = 2'd3;

	// Data stage codes
	localparam logic [1:0] STAGE_NONE = 2'd0;
	localparam logic [1:0] STAGE_IN   = 2'd1;
	localparam logic [1:0] STAGE_OUT  = 2'd2;

	// Transmit actions
	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_ZEROS = 2'd1;
	localparam logic [1:0] ACT_ZLP   = 2'd2;
	localparam logic [1:0] ACT_DESC  = 2'd3;

	// Device state reports
	localparam logic [1:0] REPORT_NONE       = 2'd0;
	localparam logic [1:0] REPORT_CONFIGURED = 2'd1;
	localparam logic [1:0] REPORT_ADDRESSED  = 2'd2;

	// bmRequestType values and direction bit
	localparam logic [7:0] RTYPE_TO_HOST = 8'h80;
	localparam logic [7:0] RTYPE_TO_DEV  = 8'h00;
	localparam int unsigned DIR_IN_BIT   = 7;

	// Standard request codes
	localparam logic [7:0] REQ_GET_STATUS        = 8'h00;
	localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'h01;
	localparam logic [7:0] REQ_SET_FEATURE       = 8'h03;
	localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
	localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
	localparam logic [7:0] REQ_SET_DESCRIPTOR    = 8'h07;
	localparam logic [7:0] REQ_GET_CONFIGURATION = 8'h08;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;

	// Packet size limits
	localparam logic [6:0] PKT_MIN   = 7'd8;
	localparam logic [6:0] PKT_MAX   = 7'd64;
	localparam logic [6:0] PKT_RESET = 7'd64;

	// Byte counts for the zero-filled answers
	localparam logic [6:0] LEN_STATUS = 7'd2;
	localparam logic [6:0] LEN_CONFIG = 7'd1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] request_value;
		logic [15:0] request_length;
		logic [6:0]  rx_length;
		logic        descriptor_present;
		logic [15:0] descriptor_length;
	} item_t;

	typedef struct packed {
		logic [1:0]  tx_action;
		logic [15:0] tx_offset;
		logic [6:0]  tx_length;
		logic        rx_rearm;
		logic        address_apply;
		logic [6:0]  device_address;
		logic [1:0]  state_report;
		logic        descriptor_release;
		logic [1:0]  stage_now;
	} result_t;

endpackage

[hw/rtl/usb_control_endpoint_requests.sv]
// Top level of the USB control endpoint request block: packet size register,
// input register and decode core. Depends on ucer_pkg, ucer_in_reg, ucer_core.
//
//   channel   direction  handshake                  payload
//   item      in         item_valid/item_stall      item (ucer_pkg::item_t)
//   result    out        result_valid/result_stall  result (ucer_pkg::result_t)
//   cfg       in         cfg_valid/cfg_ready        cfg_data (packet size, 7 bits)
//
// One event is accepted per clock while the result is not stalled; its result
// passes through the input register and then the result register.
// The combinational decode between them updates the control state, so events
// follow each other with no gap. A stalled result holds the core, and the
// input register then holds one more event before item_stall rises.
// Reset clears control state and sets the packet size to 64; cfg is always ready.
module usb_control_endpoint_requests (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  ucer_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_stall,
	output ucer_pkg::result_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         cfg_data
);

	logic [6:0]        tx_size_q;
	logic              valid_s1;
	ucer_pkg::item_t   item_s1;
	logic              advance;

	assign cfg_ready = 1'b1;

	// Hold the packet size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_size_q <= ucer_pkg::PKT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tx_size_q <= cfg_data;
		end
	end

	ucer_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	ucer_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.tx_buffer_size (tx_size_q),
		.valid_s1       (valid_s1),
		.item_s1        (item_s1),
		.advance        (advance),
		.valid_s2       (result_valid),
		.result_stall   (result_stall),
		.result_s2      (result)
	);

	// Packet size register is written only through the cfg transfer
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_valid && cfg_ready) |=> $stable(tx_size_q))
		else $error("packet size changed without a cfg transfer");

endmodule

[hw/rtl/ucer_in_reg.sv]
// Input register of the USB control endpoint request block.
// Depends on ucer_pkg for the item struct.
module ucer_in_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  ucer_pkg::item_t  item,
	input  logic             advance,
	output logic             valid_s1,
	output ucer_pkg::item_t  item_s1
);

	logic accept;

	// Take a new transfer when the register is empty or drains this cycle
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	// Hold the occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

endmodule

[hw/rtl/ucer_core.sv]
// Request decode, control state and result register of the USB control
// endpoint request block. Depends on ucer_pkg.
module ucer_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [6:0]         tx_buffer_size,
	input  logic               valid_s1,
	input  ucer_pkg::item_t    item_s1,
	output logic               advance,
	output logic               valid_s2,
	input  logic               result_stall,
	output ucer_pkg::result_t  result_s2
);

	logic [1:0]  data_stage_q;
	logic [6:0]  address_latch_q;
	logic        pending_active_q;
	logic [15:0] pending_offset_q;
	logic [15:0] pending_total_q;

	logic [1:0]  data_stage_n;
	logic [6:0]  address_latch_n;
	logic        pending_active_n;
	logic [15:0] pending_offset_n;
	logic [15:0] pending_total_n;
	ucer_pkg::result_t res_n;

	logic        fire;
	logic [6:0]  limit;

	assign advance = !valid_s2 || !result_stall;
	assign fire    = valid_s1 && advance;

	// Clamp the packet size register into range
	always_comb begin
		if (tx_buffer_size < ucer_pkg::PKT_MIN) begin
			limit = ucer_pkg::PKT_MIN;
		end else if (tx_buffer_size > ucer_pkg::PKT_MAX) begin
			limit = ucer_pkg::PKT_MAX;
		end else begin
			limit = tx_buffer_size;
		end
	end

	// Decode one event against the current state
	always_comb begin
		logic        to_host;
		logic        to_dev;
		logic [15:0] shorter;
		logic [6:0]  first_len;
		logic [15:0] remaining;
		logic [6:0]  chunk;
		logic [15:0] next_off;

		data_stage_n     = data_stage_q;
		address_latch_n  = address_latch_q;
		pending_active_n = pending_active_q;
		pending_offset_n = pending_offset_q;
		pending_total_n  = pending_total_q;
		res_n            = '0;

		to_host = item_s1.request_type == ucer_pkg::RTYPE_TO_HOST;
		to_dev  = item_s1.request_type == ucer_pkg::RTYPE_TO_DEV;

		// First descriptor chunk size
		shorter = (item_s1.request_length < item_s1.descriptor_length) ?
			item_s1.request_length : item_s1.descriptor_length;
		first_len = (shorter < {9'd0, limit}) ? shorter[6:0] : limit;

		// Next chunk of a pending descriptor
		remaining = (pending_offset_q < pending_total_q) ?
			pending_total_q - pending_offset_q : 16'd0;
		chunk    = (remaining < {9'd0, limit}) ? remaining[6:0] : limit;
		next_off = pending_offset_q + {9'd0, chunk};

		unique case (item_s1.cmd)
			ucer_pkg::CMD_SETUP: begin
				res_n.rx_rearm = 1'b1;
				if (item_s1.request_length != 16'd0) begin
					data_stage_n = item_s1.request_type[ucer_pkg::DIR_IN_BIT] ?
						ucer_pkg::STAGE_IN : ucer_pkg::STAGE_OUT;
				end else begin
					data_stage_n = ucer_pkg::STAGE_NONE;
				end
				priority if (item_s1.request_code == ucer_pkg::REQ_GET_STATUS && to_host) begin
					res_n.tx_action = ucer_pkg::ACT_ZEROS;
					res_n.tx_length = ucer_pkg::LEN_STATUS;
				end else if ((item_s1.request_code == ucer_pkg::REQ_CLEAR_FEATURE ||
						item_s1.request_code == ucer_pkg::REQ_SET_FEATURE ||
						item_s1.request_code == ucer_pkg::REQ_SET_DESCRIPTOR) && to_dev) begin
					res_n.tx_action = ucer_pkg::ACT_ZLP;
				end else if (item_s1.request_code == ucer_pkg::REQ_SET_ADDRESS && to_dev) begin
					address_latch_n = item_s1.request_value[6:0];
					res_n.tx_action = ucer_pkg::ACT_ZLP;
				end else if (item_s1.request_code == ucer_pkg::REQ_GET_DESCRIPTOR &&
						to_host) begin
					if (item_s1.descriptor_present) begin
						res_n.tx_action = ucer_pkg::ACT_DESC;
						res_n.tx_length = first_len;
						if (item_s1.request_length > {9'd0, first_len} &&
								item_s1.descriptor_length > {9'd0, first_len}) begin
							pending_active_n = 1'b1;
							pending_offset_n = {9'd0, first_len};
							pending_total_n  = item_s1.descriptor_length;
						end else begin
							res_n.descriptor_release = 1'b1;
						end
					end
				end else if (item_s1.request_code == ucer_pkg::REQ_GET_CONFIGURATION &&
						to_host) begin
					res_n.tx_action = ucer_pkg::ACT_ZEROS;
					res_n.tx_length = ucer_pkg::LEN_CONFIG;
				end else if (item_s1.request_code == ucer_pkg::REQ_SET_CONFIGURATION &&
						to_dev) begin
					res_n.state_report = ucer_pkg::REPORT_CONFIGURED;
					res_n.tx_action    = ucer_pkg::ACT_ZLP;
				end else begin
					res_n.tx_action = ucer_pkg::ACT_NONE;
				end
			end
			ucer_pkg::CMD_RX_DONE, ucer_pkg::CMD_TX_DONE: begin
				res_n.rx_rearm = item_s1.cmd == ucer_pkg::CMD_RX_DONE;
				// Continue the in data stage
				if (data_stage_q == ucer_pkg::STAGE_IN) begin
					if (item_s1.rx_length == 7'd0) begin
						data_stage_n = ucer_pkg::STAGE_NONE;
					end
					if (pending_active_q) begin
						res_n.tx_action = ucer_pkg::ACT_DESC;
						res_n.tx_offset = pending_offset_q;
						res_n.tx_length = chunk;
						pending_offset_n = next_off;
						if (next_off >= pending_total_q) begin
							res_n.descriptor_release = 1'b1;
							pending_active_n = 1'b0;
							pending_offset_n = 16'd0;
							pending_total_n  = 16'd0;
						end
					end
				end
				// Status stage: apply a latched address
				if (data_stage_n == ucer_pkg::STAGE_NONE && address_latch_q != 7'd0) begin
					res_n.address_apply  = 1'b1;
					res_n.device_address = address_latch_q;
					res_n.state_report   = ucer_pkg::REPORT_ADDRESSED;
					address_latch_n      = 7'd0;
				end
			end
			ucer_pkg::CMD_BUS_RST: begin
				res_n.rx_rearm = 1'b1;
			end
			default: begin
				res_n.rx_rearm = 1'b1;
			end
		endcase

		res_n.stage_now = data_stage_n;
	end

	// Advance control state on each decoded transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_stage_q     <= ucer_pkg::STAGE_NONE;
			address_latch_q  <= 7'd0;
			pending_active_q <= 1'b0;
			pending_offset_q <= 16'd0;
			pending_total_q  <= 16'd0;
			valid_s2         <= 1'b0;
		end else begin
			if (fire) begin
				data_stage_q     <= data_stage_n;
				address_latch_q  <= address_latch_n;
				pending_active_q <= pending_active_n;
				pending_offset_q <= pending_offset_n;
				pending_total_q  <= pending_total_n;
				valid_s2         <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= res_n;
		end
	end

	// A released transfer always ends with a descriptor chunk
	a_release_is_desc: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.descriptor_release |-> result_s2.tx_action == ucer_pkg::ACT_DESC)
		else $error("descriptor release without descriptor chunk");

	// Address application carries a nonzero address and the addressed report
	a_apply_addr: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.address_apply |->
			result_s2.device_address != 7'd0 &&
			result_s2.state_report == ucer_pkg::REPORT_ADDRESSED)
		else $error("address applied without address or report");

	// Chunks never exceed the largest packet
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> result_s2.tx_length <= ucer_pkg::PKT_MAX)
		else $error("transmit length above packet maximum");

	// Pending offset never passes the total
	a_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_active_q |-> pending_offset_q <= pending_total_q &&
			pending_offset_q != 16'd0)
		else $error("pending offset out of range");

	// A stalled result is not overwritten
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_stall |=> $stable(result_s2))
		else $error("stalled result changed");

endmodule
